FILE: hw/rtl/vfue_pkg.sv
// ----------------------------------------------------------------------------
// Value function update engine package
// Shared constants, codes, types and fixed-point helpers.
// ----------------------------------------------------------------------------
package vfue_pkg;

   // Storage sizing
   localparam int TABLE_DEPTH  = 1024;
   localparam int MAX_FEATURES = 8;
   localparam int TAB_AW       = $clog2(TABLE_DEPTH);
   localparam int WEIGHT_DEPTH = MAX_FEATURES + 1;
   localparam int WIDX_W       = $clog2(WEIGHT_DEPTH);

   // Item field widths
   localparam int INDEX_W  = 10;
   localparam int FEAT_W   = 16;
   localparam int NUM_FEAT = 8;
   localparam int FEAT_IW  = $clog2(NUM_FEAT);
   localparam int VALUE_W  = 32;
   localparam int REQ_DATA_W = 176;

   // Datapath widths
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 58;
   localparam int DELTA_W = 44;
   localparam int ERR_W   = VALUE_W + 1;

   // Configuration register indexes
   localparam logic [1:0] CSR_APPROX_KIND  = 2'd0;
   localparam logic [1:0] CSR_TABLE_RATE   = 2'd1;
   localparam logic [1:0] CSR_LINEAR_RATE  = 2'd2;
   localparam logic [1:0] CSR_FEATURES_USE = 2'd3;

   // Estimator kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_TABLE  = 2'd1;
   localparam logic [1:0] KIND_LINEAR = 2'd2;

   // Request modes
   localparam logic MODE_QUERY  = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAB_READ,
      ST_TAB_WRITE,
      ST_LIN_DOT,
      ST_LIN_VAL,
      ST_LIN_ERR,
      ST_LIN_SCALE,
      ST_LIN_UPD,
      ST_LIN_BIAS
   } vfue_state_type;

   typedef struct packed {
      logic                      en;
      logic [WIDX_W-1:0]         idx;
      logic signed [DELTA_W-1:0] delta;
   } weight_wr_type;

   function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [VALUE_W-1:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = VALUE_W'(x);
      end
      return r;
   endfunction

   // Reduce the state index modulo the table depth by restoring subtraction
   function automatic logic [TAB_AW-1:0] wrap_index(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] v;
      v = idx;
      for (int k = INDEX_W - 1; k >= 0; k--) begin
         if ((longint'(TABLE_DEPTH) << k) < (longint'(1) << INDEX_W)) begin
            if (v >= INDEX_W'(longint'(TABLE_DEPTH) << k)) begin
               v = v - INDEX_W'(longint'(TABLE_DEPTH) << k);
            end
         end
      end
      return TAB_AW'(v);
   endfunction

endpackage

FILE: hw/rtl/vfue_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfue_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/vfue_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by every multiplying step.
// ----------------------------------------------------------------------------
module vfue_mul (
   input  logic                                 clock,
   input  logic signed [vfue_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [vfue_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [vfue_pkg::PROD_W-1:0]   prod
);
   import vfue_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: hw/rtl/vfue_weights.sv
// ----------------------------------------------------------------------------
// Weight store
// Linear weights with one read port and a saturating accumulate write port.
// ----------------------------------------------------------------------------
module vfue_weights (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [vfue_pkg::WIDX_W-1:0]          rd_idx,
   output logic signed [vfue_pkg::VALUE_W-1:0]  rd_data,
   input  vfue_pkg::weight_wr_type              wr
);
   import vfue_pkg::*;

   logic signed [VALUE_W-1:0] weight_ff [WEIGHT_DEPTH];
   logic signed [VALUE_W-1:0] weight_in;

   assign weight_in = sat32(64'(weight_ff[wr.idx]) + 64'(wr.delta));
   assign rd_data   = weight_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WEIGHT_DEPTH; i++) begin
            weight_ff[i] <= '0;
         end
      end else if (wr.en) begin
         weight_ff[wr.idx] <= weight_in;
      end
   end

endmodule

FILE: hw/rtl/value_function_update_engine.sv
// ----------------------------------------------------------------------------
// Value function update engine
// Tabular or linear state-value estimate with query and LMS update.
//
//   Channel  Ports                            Carries
//   req      req_tvalid/tready/tdata/tuser    tuser: mode; tdata: index,
//                                             features a..h, reward
//   rsp      rsp_tvalid/tready/tdata          tdata: value (before update)
//   csr      csr_valid/ready/index/data       register writes, always ready
//
// Tabular items pass the table read step and, for an update, the write step;
// linear items step once through the features in use for the dot product
// and, for an update, once more for the weight steps, on the single
// shared multiplier. After reset the value table is cleared while req_tready
// is low. A new request is taken only once the result register is emptied.
// ----------------------------------------------------------------------------
module value_function_update_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] state_index, [25:10] feature_a, [41:26] feature_b,
   // [57:42] feature_c, [73:58] feature_d, [89:74] feature_e,
   // [105:90] feature_f, [121:106] feature_g, [137:122] feature_h,
   // [169:138] reward, [175:170] zero
   input  logic [vfue_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] value
   output logic [vfue_pkg::VALUE_W-1:0]        rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [15:0]                         csr_data
);
   import vfue_pkg::*;

   // Configuration
   logic [1:0]  kind_ff;
   logic [15:0] trate_ff;
   logic [15:0] lrate_ff;
   logic [3:0]  fiu_ff;
   logic [WIDX_W-1:0] n_used;

   // Sequencer and item registers
   vfue_state_type state_ff, state_in;
   logic [WIDX_W-1:0]  cnt_ff, cnt_in;
   logic [TAB_AW-1:0]  clr_ff, clr_in;
   logic               mode_ff, mode_in;
   logic [TAB_AW-1:0]  addr_ff, addr_in;
   logic signed [FEAT_W-1:0]  feat_ff [NUM_FEAT];
   logic signed [VALUE_W-1:0] reward_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic signed [MUL_A_W-1:0] e_ff, e_in;
   logic               pend_ff, pend_in;
   logic               wpend_ff, wpend_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;

   // Datapath signals
   logic                      req_fire;
   logic                      ram_we;
   logic [TAB_AW-1:0]         ram_waddr;
   logic [VALUE_W-1:0]        ram_wdata;
   logic [TAB_AW-1:0]         ram_raddr;
   logic [VALUE_W-1:0]        ram_rdata;
   logic signed [VALUE_W-1:0] tab_q;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [WIDX_W-1:0]         w_rd_idx;
   logic signed [VALUE_W-1:0] w_rd;
   weight_wr_type             w_wr;
   logic signed [FEAT_W-1:0]  feat_sel;
   logic signed [VALUE_W-1:0] lin_val;
   logic signed [ERR_W-1:0]   err_tab;
   logic signed [ERR_W-1:0]   err_lin;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign n_used   = (fiu_ff > 4'(MAX_FEATURES)) ? WIDX_W'(MAX_FEATURES) : WIDX_W'(fiu_ff);
   assign tab_q    = signed'(ram_rdata);
   assign feat_sel = feat_ff[FEAT_IW'(cnt_ff)];
   assign lin_val  = sat32(64'(acc_ff >>> 8));
   assign err_tab  = ERR_W'(reward_ff) - ERR_W'(tab_q);
   assign err_lin  = ERR_W'(reward_ff) - ERR_W'(val_ff);

   vfue_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   vfue_mul u_mul (
      .clock(clock),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .prod (prod)
   );

   vfue_weights u_weights (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (w_rd_idx),
      .rd_data(w_rd),
      .wr     (w_wr)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_TABLE;
         trate_ff <= 16'd6554;
         lrate_ff <= 16'd6554;
         fiu_ff   <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_APPROX_KIND:  kind_ff  <= csr_data[1:0];
            CSR_TABLE_RATE:   trate_ff <= csr_data;
            CSR_LINEAR_RATE:  lrate_ff <= csr_data;
            CSR_FEATURES_USE: fiu_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      acc_ff      <= acc_in;
      val_ff      <= val_in;
      e_ff        <= e_in;
      widx_ff     <= widx_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         for (int i = 0; i < NUM_FEAT; i++) begin
            feat_ff[i] <= signed'(req_tdata[INDEX_W + FEAT_W*i +: FEAT_W]);
         end
         reward_ff <= signed'(req_tdata[INDEX_W + FEAT_W*NUM_FEAT +: VALUE_W]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      e_in         = e_ff;
      widx_in      = widx_ff;
      pend_in      = 1'b0;
      wpend_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = addr_ff;
      mul_a        = '0;
      mul_b        = '0;
      w_rd_idx     = cnt_ff;
      w_wr         = '0;

      // accumulate the product issued last cycle
      if (pend_ff) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
      // retire the weight step issued last cycle
      if (wpend_ff) begin
         w_wr.en    = 1'b1;
         w_wr.idx   = widx_ff;
         w_wr.delta = DELTA_W'(prod >>> 8);
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == TAB_AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            w_rd_idx  = n_used;
            ram_raddr = wrap_index(req_tdata[INDEX_W-1:0]);
            if (req_fire) begin
               mode_in = req_tuser;
               addr_in = wrap_index(req_tdata[INDEX_W-1:0]);
               cnt_in  = '0;
               // bias weight times 1.0 in Q24.24
               acc_in  = ACC_W'(w_rd) <<< 24;
               case (kind_ff)
                  KIND_TABLE:  state_in = ST_TAB_READ;
                  KIND_LINEAR: state_in = ST_LIN_DOT;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         ST_TAB_READ: begin
            val_in = tab_q;
            mul_a  = MUL_A_W'(err_tab);
            mul_b  = signed'({1'b0, trate_ff});
            if (mode_ff == MODE_UPDATE) begin
               state_in = ST_TAB_WRITE;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tab_q;
               state_in     = ST_IDLE;
            end
         end
         ST_TAB_WRITE: begin
            ram_we       = 1'b1;
            ram_wdata    = sat32(64'(val_ff) + 64'(prod >>> 16));
            rsp_valid_in = 1'b1;
            rsp_data_in  = val_ff;
            state_in     = ST_IDLE;
         end
         ST_LIN_DOT: begin
            if (cnt_ff < n_used) begin
               mul_a   = MUL_A_W'(w_rd);
               mul_b   = MUL_B_W'(feat_sel);
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = ST_LIN_VAL;
            end
         end
         ST_LIN_VAL: begin
            val_in = lin_val;
            if (mode_ff == MODE_UPDATE) begin
               state_in = ST_LIN_ERR;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = lin_val;
               state_in     = ST_IDLE;
            end
         end
         ST_LIN_ERR: begin
            mul_a    = MUL_A_W'(err_lin);
            mul_b    = signed'({1'b0, lrate_ff});
            state_in = ST_LIN_SCALE;
         end
         ST_LIN_SCALE: begin
            e_in     = MUL_A_W'(prod >>> 16);
            cnt_in   = '0;
            state_in = ST_LIN_UPD;
         end
         ST_LIN_UPD: begin
            if (cnt_ff < n_used) begin
               mul_a    = e_ff;
               mul_b    = MUL_B_W'(feat_sel);
               wpend_in = 1'b1;
               widx_in  = cnt_ff;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               state_in = ST_LIN_BIAS;
            end
         end
         ST_LIN_BIAS: begin
            w_wr.en      = 1'b1;
            w_wr.idx     = n_used;
            w_wr.delta   = DELTA_W'(e_ff);
            rsp_valid_in = 1'b1;
            rsp_data_in  = val_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Value function update engine testbench
// Drives query and update requests through the tabular, linear and disabled
// estimator kinds across many register settings. A built-in estimator keeps
// its own value table and weight vector, predicts each returned value and
// compares it with the response stream under random idling and a long
// response hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vfue_pkg::*;

   typedef struct packed {
      logic                            mode;
      logic [INDEX_W-1:0]              state_index;
      logic [NUM_FEAT-1:0][FEAT_W-1:0] feature;
      logic [VALUE_W-1:0]              reward;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_W-1:0]    rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [15:0]           csr_data = '0;

   // estimator mirror
   logic signed [VALUE_W-1:0] value_mirror [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] weight_mirror [WEIGHT_DEPTH];
   logic [1:0]                kind_cfg;
   logic [15:0]               table_rate_cfg;
   logic [15:0]               linear_rate_cfg;
   logic [3:0]                features_cfg;

   logic [VALUE_W-1:0] value_expect_q [$];

   int fail_count     = 0;
   int requests_sent  = 0;
   int values_checked = 0;
   int csr_writes     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   value_function_update_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [VALUE_W-1:0] saturate_q16(input longint x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // Return the current estimate and apply the learning step for an update.
   task automatic estimate_and_learn(input request_type r,
                                     output logic [VALUE_W-1:0] v);
      longint acc;
      longint err;
      longint scaled;
      longint feat;
      int     n;
      logic signed [VALUE_W-1:0] cur;
      cur = '0;
      if (kind_cfg == KIND_TABLE) begin
         cur = value_mirror[r.state_index];
         if (r.mode == MODE_UPDATE) begin
            err = longint'($signed(r.reward)) - longint'(cur);
            scaled = (longint'(table_rate_cfg) * err) >>> 16;
            value_mirror[r.state_index] = saturate_q16(longint'(cur) + scaled);
         end
      end else if (kind_cfg == KIND_LINEAR) begin
         n = (features_cfg > MAX_FEATURES) ? MAX_FEATURES : int'(features_cfg);
         acc = longint'(weight_mirror[n]) * 64'sd16777216;
         for (int i = 0; i < n; i++) begin
            acc += longint'(weight_mirror[i]) * longint'($signed(r.feature[i]));
         end
         cur = saturate_q16(acc >>> 8);
         if (r.mode == MODE_UPDATE) begin
            err = longint'($signed(r.reward)) - longint'(cur);
            scaled = (longint'(linear_rate_cfg) * err) >>> 16;
            for (int i = 0; i < n; i++) begin
               feat = longint'($signed(r.feature[i]));
               weight_mirror[i] = saturate_q16(longint'(weight_mirror[i]) +
                                               ((scaled * feat) >>> 8));
            end
            weight_mirror[n] = saturate_q16(longint'(weight_mirror[n]) + scaled);
         end
      end
      v = cur;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      $display("ERROR %0t: %s: expected %h got %h", $time, what, want, got);
   endtask

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         values_checked++;
         if (value_expect_q.size() == 0) begin
            report_mismatch("value with no request waiting", '0, rsp_tdata);
         end else if (value_expect_q[0] !== rsp_tdata) begin
            report_mismatch("value", value_expect_q[0], rsp_tdata);
            void'(value_expect_q.pop_front());
         end else begin
            void'(value_expect_q.pop_front());
         end
      end
   end

   // Response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input request_type r);
      logic [VALUE_W-1:0] v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= REQ_DATA_W'({r.reward, r.feature, r.state_index});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      estimate_and_learn(r, v);
      value_expect_q.push_back(v);
      requests_sent++;
   endtask

   // Drop the request, wait for every value and for the engine to go idle.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (value_expect_q.size() != 0) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_APPROX_KIND:  kind_cfg        = data[1:0];
         CSR_TABLE_RATE:   table_rate_cfg  = data;
         CSR_LINEAR_RATE:  linear_rate_cfg = data;
         CSR_FEATURES_USE: features_cfg    = data[3:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic configure(input logic [15:0] kind_word, input logic [15:0] trate,
                            input logic [15:0] lrate, input logic [15:0] nfeat_word);
      write_csr(CSR_APPROX_KIND, kind_word);
      write_csr(CSR_TABLE_RATE, trate);
      write_csr(CSR_LINEAR_RATE, lrate);
      write_csr(CSR_FEATURES_USE, nfeat_word);
      csr_valid <= 1'b0;
   endtask

   function automatic request_type make_request(input logic mode, input logic [9:0] idx,
                                                input logic [15:0] feat,
                                                input logic [31:0] reward);
      request_type r;
      r.mode        = mode;
      r.state_index = idx;
      r.reward      = reward;
      for (int i = 0; i < NUM_FEAT; i++) r.feature[i] = feat;
      return r;
   endfunction

   function automatic logic [15:0] pick_feature();
      case ($urandom_range(4))
         0, 1:    return 16'($urandom);
         2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(2047) - 1024);
      endcase
   endfunction

   function automatic logic [31:0] pick_reward();
      case ($urandom_range(5))
         0, 1:    return $urandom;
         2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [9:0] pick_index();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 10'd0 : 10'd1023;
         1, 2, 3: return 10'($urandom);
         default: return 10'($urandom_range(15));
      endcase
   endfunction

   function automatic logic [15:0] pick_rate();
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(1024));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.mode        = $urandom_range(2) != 0 ? MODE_UPDATE : MODE_QUERY;
      r.state_index = pick_index();
      r.reward      = pick_reward();
      for (int i = 0; i < NUM_FEAT; i++) r.feature[i] = pick_feature();
      return r;
   endfunction

   task automatic random_settings();
      logic [1:0]  kind;
      logic [3:0]  nfeat;
      logic [15:0] junk;
      case ($urandom_range(9))
         0:             kind = KIND_NONE;
         1:             kind = 2'd3;
         2, 3, 4, 5:    kind = KIND_TABLE;
         default:       kind = KIND_LINEAR;
      endcase
      case ($urandom_range(5))
         0:       nfeat = 4'd0;
         1:       nfeat = 4'd8;
         2:       nfeat = 4'($urandom_range(9, 15));
         default: nfeat = 4'($urandom_range(1, 7));
      endcase
      // upper bits of the narrow registers must be dropped
      junk = $urandom_range(3) == 0 ? 16'($urandom) : 16'd0;
      configure({junk[15:2], kind}, pick_rate(), pick_rate(), {junk[15:4], nfeat});
   endtask

   task automatic test_table_directed();
      wait_for_results();
      configure({14'd0, KIND_TABLE}, 16'hffff, 16'd6554, 16'd8);
      send_request(make_request(MODE_QUERY, 10'd0, 16'h0000, 32'h0));
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h7fff, 32'h7fffffff));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h8000, 32'h0));
      send_request(make_request(MODE_UPDATE, 10'd1023, 16'h0000, 32'h80000000));
      send_request(make_request(MODE_QUERY, 10'd1023, 16'h0000, 32'h0));
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h0000, 32'h80000000));
      wait_for_results();
      configure({14'd0, KIND_TABLE}, 16'd0, 16'd6554, 16'd8);
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h0000, 32'h00012345));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h0000, 32'h0));
   endtask

   task automatic test_linear_directed();
      request_type r;
      wait_for_results();
      configure({14'd0, KIND_LINEAR}, 16'd6554, 16'hffff, 16'd8);
      send_request(make_request(MODE_UPDATE, 10'd3, 16'h7fff, 32'h7fffffff));
      send_request(make_request(MODE_QUERY, 10'd3, 16'h7fff, 32'h0));
      send_request(make_request(MODE_UPDATE, 10'd3, 16'h8000, 32'h80000000));
      r = make_request(MODE_QUERY, 10'd3, 16'h7fff, 32'h0);
      for (int i = 1; i < NUM_FEAT; i += 2) r.feature[i] = 16'h8000;
      send_request(r);
      wait_for_results();
      // bias only
      configure({14'd0, KIND_LINEAR}, 16'd6554, 16'hffff, 16'd0);
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h1234, 32'h00010000));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h7fff, 32'h0));
      wait_for_results();
      // count above the feature limit, learning off
      configure({14'd0, KIND_LINEAR}, 16'd6554, 16'd0, 16'd15);
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h0100, 32'h00050000));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h0100, 32'h0));
      wait_for_results();
      configure({14'd0, KIND_LINEAR}, 16'd6554, 16'h8000, 16'd3);
      send_request(make_request(MODE_UPDATE, 10'd0, 16'hff00, 32'hfffd0000));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h0080, 32'h0));
   endtask

   task automatic test_kind_none();
      wait_for_results();
      configure({14'd0, KIND_NONE}, 16'hffff, 16'hffff, 16'd8);
      send_request(make_request(MODE_UPDATE, 10'd0, 16'h7fff, 32'h7fffffff));
      send_request(make_request(MODE_QUERY, 10'd0, 16'h7fff, 32'h0));
      wait_for_results();
      configure(16'd3, 16'hffff, 16'hffff, 16'd8);
      send_request(make_request(MODE_UPDATE, 10'd1023, 16'h8000, 32'h80000000));
      send_request(make_request(MODE_QUERY, 10'd1023, 16'h8000, 32'h0));
      wait_for_results();
      // table contents must have survived
      configure({14'd0, KIND_TABLE}, 16'hffff, 16'hffff, 16'd8);
      send_request(make_request(MODE_QUERY, 10'd0, 16'h0000, 32'h0));
   endtask

   task automatic test_result_backpressure();
      wait_for_results();
      configure({14'd0, KIND_LINEAR}, 16'd6554, 16'd3000, 16'd8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 300;
      for (int i = 0; i < 12; i++) send_request(random_request());
      // pause the sender until every value is back
      wait_for_results();
      configure({14'd0, KIND_TABLE}, 16'd30000, 16'd3000, 16'd8);
      hold_request = 150;
      for (int i = 0; i < 8; i++) send_request(random_request());
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      wait_for_results();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int blk = 0; blk < 3; blk++) begin
         wait_for_results();
         random_settings();
         for (int i = 0; i < count / 3; i++) send_request(random_request());
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) value_mirror[i] = '0;
      for (int i = 0; i < WEIGHT_DEPTH; i++) weight_mirror[i] = '0;
      kind_cfg        = KIND_TABLE;
      table_rate_cfg  = 16'd6554;
      linear_rate_cfg = 16'd6554;
      features_cfg    = 4'd8;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // hold off until the table clear after reset is done
      while (!req_tready) @(posedge clock);

      test_table_directed();
      test_linear_directed();
      test_kind_none();
      test_result_backpressure();
      test_random_traffic(0, 0, 150);
      test_random_traffic(52, 0, 150);
      test_random_traffic(0, 52, 150);
      test_random_traffic(14, 14, 150);

      wait_for_results();
      repeat (40) @(posedge clock);
      $display("Covered %0d requests and %0d values over %0d register writes",
               requests_sent, values_checked, csr_writes);
      $display("Kinds none, table and linear; feature counts 0 to 15; idle and stall mixes");
      if (fail_count == 0 && value_expect_q.size() == 0) begin
         $display("value_function_update_engine: match");
      end else begin
         $display("value_function_update_engine: mismatch");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d values outstanding", value_expect_q.size());
      $display("value_function_update_engine: mismatch");
      $finish;
   end

endmodule
